[design/cbd_pkg.sv]
// ----------------------------------------------------------------------------
// cbd_pkg: shared types and constants for the chunked body decoder
// Parse phases, end-of-body status codes, the result record and the
// character helpers used by the size line parser.
// ----------------------------------------------------------------------------
package cbd_pkg;

  // Parse phase; line phases come first so a single compare finds them
  typedef enum logic [3:0] {
    PH_WS     = 4'd0,
    PH_SIGN   = 4'd1,
    PH_ZERO   = 4'd2,
    PH_X      = 4'd3,
    PH_DIGITS = 4'd4,
    PH_REST   = 4'd5,
    PH_DATA   = 4'd6,
    PH_TRAIL1 = 4'd7,
    PH_TRAIL2 = 4'd8,
    PH_STOP   = 4'd9
  } cbd_phase_t;

  // Reason given with the closing result of a body
  typedef enum logic [2:0] {
    ST_TERM      = 3'd0,
    ST_BOUNDARY  = 3'd1,
    ST_IN_LINE   = 3'd2,
    ST_MID_CHUNK = 3'd3,
    ST_NEGATIVE  = 3'd4,
    ST_OVERFLOW  = 3'd5
  } cbd_status_t;

  // One result item
  typedef struct packed {
    cbd_status_t status;
    logic        is_last;
    logic        data_valid;
    logic [7:0]  data_byte;
  } cbd_result_t;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_HT    = 8'h09;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_X_LC  = 8'h78;
  localparam logic [7:0] CH_X_UC  = 8'h58;

  // Whitespace as strtoul sees it: space, HT, LF, VT, FF, CR
  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_HT) && (c <= CH_CR));
  endfunction

  // Hex digit decode: bit 4 marks a digit, bits 3:0 hold its value
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39)      r = {1'b1, c[3:0]};
    else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, c[3:0] + 4'd9};
    else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, c[3:0] + 4'd9};
    return r;
  endfunction

endpackage

[design/cbd_core.sv]
// ----------------------------------------------------------------------------
// cbd_core: framing state and per-byte decode step
// Holds the parse state, works out the result for the byte in the input
// register and advances the state when that byte leaves the register.
// ----------------------------------------------------------------------------
module cbd_core import cbd_pkg::*; #(
  parameter int SIZE_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step_en,
  input  logic [7:0]  byte_i,
  input  logic        last_i,
  output logic        has_result,
  output cbd_result_t result
);

  cbd_phase_t           phase_r, phase_nxt, ph_step, ph_a;
  logic                 begun_r, begun_nxt, begun_step;
  logic                 pcr_r, pcr_nxt, pcr_step;
  logic [SIZE_BITS-1:0] cnt_r, cnt_nxt, cnt_step, cnt_dec;
  logic                 neg_r, neg_nxt, neg_step;
  logic                 big_r, big_nxt, big_step;
  cbd_status_t          stop_r, stop_nxt, stop_step;
  logic                 data_step;
  logic [4:0]           hd;
  logic                 dig_ok;

  assign hd      = hex_digit(byte_i);
  assign cnt_dec = cnt_r - {{(SIZE_BITS-1){1'b0}}, 1'b1};

  // Decode one byte against the current state
  always_comb begin
    ph_step    = phase_r;
    begun_step = begun_r;
    pcr_step   = pcr_r;
    cnt_step   = cnt_r;
    neg_step   = neg_r;
    big_step   = big_r;
    stop_step  = stop_r;
    data_step  = 1'b0;
    ph_a       = phase_r;
    dig_ok     = 1'b0;
    case (phase_r)
      PH_WS, PH_SIGN, PH_ZERO, PH_X, PH_DIGITS, PH_REST: begin
        begun_step = 1'b1;
        if (pcr_r && byte_i == CH_LF) begin
          // CR LF closes the size line
          pcr_step   = 1'b0;
          begun_step = 1'b0;
          neg_step   = 1'b0;
          big_step   = 1'b0;
          if (big_r) begin
            stop_step = ST_OVERFLOW;
            ph_step   = PH_STOP;
          end else if (cnt_r == '0) begin
            stop_step = ST_TERM;
            ph_step   = PH_STOP;
          end else if (neg_r) begin
            stop_step = ST_NEGATIVE;
            ph_step   = PH_STOP;
          end else begin
            ph_step = PH_DATA;
          end
        end else begin
          // A held bare CR ends any digits begun so far
          if (pcr_r && phase_r != PH_WS && phase_r != PH_REST) ph_a = PH_REST;
          pcr_step = (byte_i == CH_CR);
          ph_step  = ph_a;
          if (byte_i != CH_CR) begin
            case (ph_a)
              PH_WS: begin
                if (is_space(byte_i)) begin
                  ph_step = PH_WS;
                end else if (byte_i == CH_PLUS || byte_i == CH_MINUS) begin
                  neg_step = (byte_i == CH_MINUS);
                  ph_step  = PH_SIGN;
                end else if (byte_i == CH_ZERO) begin
                  ph_step = PH_ZERO;
                end else if (hd[4]) begin
                  dig_ok = 1'b1;
                end else begin
                  ph_step = PH_REST;
                end
              end
              PH_SIGN: begin
                if (byte_i == CH_ZERO) ph_step = PH_ZERO;
                else if (hd[4])        dig_ok  = 1'b1;
                else                   ph_step = PH_REST;
              end
              PH_ZERO: begin
                if (byte_i == CH_X_LC || byte_i == CH_X_UC) ph_step = PH_X;
                else if (hd[4])                              dig_ok  = 1'b1;
                else                                         ph_step = PH_REST;
              end
              PH_X, PH_DIGITS: begin
                if (hd[4]) dig_ok  = 1'b1;
                else       ph_step = PH_REST;
              end
              default: ph_step = ph_a;
            endcase
            // Shift in a digit unless the top nibble would overflow
            if (dig_ok) begin
              ph_step = PH_DIGITS;
              if (big_r || cnt_r[SIZE_BITS-1 -: 4] != 4'd0) begin
                big_step = 1'b1;
              end else begin
                cnt_step = {cnt_r[SIZE_BITS-5:0], hd[3:0]};
              end
            end
          end
        end
      end
      PH_DATA: begin
        data_step = 1'b1;
        cnt_step  = cnt_dec;
        if (cnt_dec == '0) ph_step = PH_TRAIL1;
      end
      PH_TRAIL1: ph_step = PH_TRAIL2;
      PH_TRAIL2: begin
        ph_step  = PH_WS;
        cnt_step = '0;
      end
      default: ph_step = PH_STOP;
    endcase
  end

  // Next state: end of body returns everything to its reset value
  always_comb begin
    if (last_i) begin
      phase_nxt = PH_WS;
      begun_nxt = 1'b0;
      pcr_nxt   = 1'b0;
      cnt_nxt   = '0;
      neg_nxt   = 1'b0;
      big_nxt   = 1'b0;
      stop_nxt  = ST_TERM;
    end else begin
      phase_nxt = ph_step;
      begun_nxt = begun_step;
      pcr_nxt   = pcr_step;
      cnt_nxt   = cnt_step;
      neg_nxt   = neg_step;
      big_nxt   = big_step;
      stop_nxt  = stop_step;
    end
  end

  // Result for this byte
  always_comb begin
    result.data_valid = data_step;
    result.data_byte  = data_step ? byte_i : 8'd0;
    result.is_last    = last_i;
    result.status     = ST_TERM;
    if (last_i) begin
      if (ph_step == PH_STOP)                  result.status = stop_step;
      else if (ph_step == PH_DATA)             result.status = ST_MID_CHUNK;
      else if (ph_step <= PH_REST && begun_step) result.status = ST_IN_LINE;
      else                                     result.status = ST_BOUNDARY;
    end
    has_result = data_step || last_i;
  end

  // Advance the state as the byte is consumed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_WS;
      begun_r <= 1'b0;
      pcr_r   <= 1'b0;
      cnt_r   <= '0;
      neg_r   <= 1'b0;
      big_r   <= 1'b0;
      stop_r  <= ST_TERM;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      begun_r <= begun_nxt;
      pcr_r   <= pcr_nxt;
      cnt_r   <= cnt_nxt;
      neg_r   <= neg_nxt;
      big_r   <= big_nxt;
      stop_r  <= stop_nxt;
    end
  end

endmodule

[design/cbd_out_reg.sv]
// ----------------------------------------------------------------------------
// cbd_out_reg: result register
// Holds one result request until the downstream side takes it.
// ----------------------------------------------------------------------------
module cbd_out_reg import cbd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        load,
  input  cbd_result_t res_i,
  input  logic        ready_i,
  output logic        valid_o,
  output cbd_result_t res_o,
  output logic        free_o
);

  logic        valid_r, valid_nxt;
  cbd_result_t res_r;

  assign free_o  = !valid_r || ready_i;
  assign valid_o = valid_r;
  assign res_o   = res_r;

  // Fill on load, drain on take
  always_comb begin
    if (load)         valid_nxt = 1'b1;
    else if (ready_i) valid_nxt = 1'b0;
    else              valid_nxt = valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else        valid_r <= valid_nxt;
  end

  // Hold the payload
  always_ff @(posedge clk) begin
    if (load) res_r <= res_i;
  end

endmodule

[design/chunked_body_decoder.sv]
// Path: a byte accepted at the input gives its result at the out_ ports
// after passing the input register, then the result register.
// Throughput: one byte per cycle unless out_tready holds back a result; the
// parse state is updated in the single step between the two registers.
// Reset: rst_n low clears the parse state and both register stages.
// ----------------------------------------------------------------------------
// chunked_body_decoder: HTTP chunked transfer framing removal
// Takes one body byte per request, strips size lines and chunk trailers, and
// passes payload bytes on with a status result at the end of each body.
// ----------------------------------------------------------------------------
module chunked_body_decoder import cbd_pkg::*; #(
  parameter int SIZE_BITS = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic       in_tlast,   // end_of_body
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] data_byte
  output logic [3:0] out_tuser,  // [0] data_valid, [3:1] status
  output logic       out_tlast   // is_last
);

  logic        s1_valid_r, s1_valid_nxt;
  logic [7:0]  s1_byte_r;
  logic        s1_last_r;
  logic        s1_move, in_take;
  logic        has_result, out_free;
  cbd_result_t res, res_q;

  assign s1_move   = s1_valid_r && (!has_result || out_free);
  assign in_tready = !s1_valid_r || s1_move;
  assign in_take   = in_tvalid && in_tready;

  // Input register
  always_comb begin
    if (in_take)      s1_valid_nxt = 1'b1;
    else if (s1_move) s1_valid_nxt = 1'b0;
    else              s1_valid_nxt = s1_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s1_valid_r <= 1'b0;
    else        s1_valid_r <= s1_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
  end

  cbd_core #(.SIZE_BITS(SIZE_BITS)) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_en    (s1_move),
    .byte_i     (s1_byte_r),
    .last_i     (s1_last_r),
    .has_result (has_result),
    .result     (res)
  );

  cbd_out_reg u_out (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (s1_move && has_result),
    .res_i   (res),
    .ready_i (out_tready),
    .valid_o (out_tvalid),
    .res_o   (res_q),
    .free_o  (out_free)
  );

  assign out_tdata = res_q.data_byte;
  assign out_tuser = {res_q.status, res_q.data_valid};
  assign out_tlast = res_q.is_last;

endmodule
